/* rtl/wall_column_span_setup_top_defines.svh */
// Assertion macros for the wall column span setup RTL.
// Included by wcs_queue, the module that carries concurrent checks; depends on nothing.
`ifndef WALL_COLUMN_SPAN_SETUP_TOP_DEFINES_SVH
`define WALL_COLUMN_SPAN_SETUP_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WCS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wcs check failed");

// The consequent must hold in the cycle after the antecedent.
`define WCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wcs check failed");

`endif

/* rtl/wcs_pkg.sv */
// Shared types and constants of the wall column span setup block.
// Used by every RTL module of the block but wcs_divider; depends on nothing.
package wcs_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH       = 4;
   localparam int CSR_ADDR_W        = 4;
   localparam int CSR_DATA_W        = 32;

   localparam logic [11:0] VIEW_MAX       = 12'd2048;
   localparam logic [10:0] TEX_MAX        = 11'd1024;
   localparam logic [11:0] VIEW_RESET     = 12'd600;
   localparam logic [10:0] TEX_COLS_RESET = 11'd64;
   localparam logic [10:0] TEX_ROWS_RESET = 11'd64;

   typedef enum logic [1:0] {
      REG_VIEW_ROWS       = 2'd0,
      REG_TEXTURE_COLUMNS = 2'd1,
      REG_TEXTURE_ROWS    = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [31:0]        wall_distance;
      logic               hit_side;
      logic signed [19:0] direction_x;
      logic signed [19:0] direction_y;
      logic [23:0]        player_x;
      logic [23:0]        player_y;
      logic [11:0]        column_in;
   } req_payload_type;

   typedef struct packed {
      logic [11:0] column_out;
      logic [10:0] first_row;
      logic [10:0] last_row;
      logic [9:0]  texel_column;
      logic [25:0] texel_start;
      logic [26:0] texel_step;
   } rsp_payload_type;

   // A classified column as it waits between the front and the back.
   typedef struct packed {
      logic [11:0]        column;
      logic [31:0]        distance;
      logic [23:0]        coord;
      logic signed [19:0] direction;
      logic               mirror;
   } column_item_type;

   // Clamped configuration as seen by the back end.
   typedef struct packed {
      logic [11:0] view_rows;
      logic [10:0] texture_columns;
      logic [10:0] texture_rows;
   } view_config_type;

endpackage

/* rtl/wcs_front.sv */
// Front end: accepts a cast ray and classifies it for the back end.
// Depends on wcs_pkg.
module wcs_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  wcs_pkg::req_payload_type    req_payload,
   output logic                        push_valid,
   output wcs_pkg::column_item_type    push_item,
   input  logic                        push_full
);
   import wcs_pkg::*;

   logic            valid_ff, valid_in;
   column_item_type item_ff, item_in;
   logic            accept;

   // The holding register stalls only while its item cannot enter the queue.
   assign req_stall  = valid_ff && push_full;
   assign accept     = req_valid && !req_stall;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   // Pick the axis of the hit position, decide on mirroring and raise a zero distance to one.
   always_comb begin
      item_in.column   = req_payload.column_in;
      item_in.distance = (req_payload.wall_distance == 32'd0) ? 32'd1
                                                              : req_payload.wall_distance;
      if (req_payload.hit_side) begin
         item_in.coord     = req_payload.player_x;
         item_in.direction = req_payload.direction_x;
         item_in.mirror    = req_payload.direction_y[19];
      end else begin
         item_in.coord     = req_payload.player_y;
         item_in.direction = req_payload.direction_y;
         item_in.mirror    = !req_payload.direction_x[19] && (req_payload.direction_x != 20'sd0);
      end
   end

   // Occupancy of the holding register.
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (valid_ff && !push_full) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

/* rtl/wcs_queue.sv */
// Short queue of classified columns between the front and back ends.
// Depends on wcs_pkg and the assertion macro header.
`include "wall_column_span_setup_top_defines.svh"
module wcs_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  wcs_pkg::column_item_type    push_item,
   output logic                        full,
   input  logic                        pop_req,
   output logic                        empty,
   output wcs_pkg::column_item_type    pop_item
);
   import wcs_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   column_item_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign push     = push_valid && !full;
   assign pop      = pop_req && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `WCS_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `WCS_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `WCS_ASSERT_NEXT(a_pop_shrinks, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1)

endmodule

/* rtl/wcs_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing but its parameters.
module wcs_divider #(
   parameter int NUM_W  = 28,
   parameter int DEN_W  = 32,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [NUM_W];
   logic [DEN_W-1:0]  rem_ff   [NUM_W];
   logic [NUM_W-1:0]  num_ff   [NUM_W];
   logic [NUM_W-1:0]  quo_ff   [NUM_W];
   logic [DEN_W-1:0]  den_ff   [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];

   genvar k;
   generate
      for (k = 0; k < NUM_W; k++) begin : g_stage
         logic              valid_p;
         logic [DEN_W-1:0]  rem_p, den_p, rem_in;
         logic [NUM_W-1:0]  num_p, quo_p;
         logic [SIDE_W-1:0] side_p;
         logic [DEN_W:0]    trial;
         logic              qbit;

         if (k == 0) begin : g_first
            assign valid_p = in_valid;
            assign rem_p   = '0;
            assign num_p   = in_num;
            assign quo_p   = '0;
            assign den_p   = in_den;
            assign side_p  = in_side;
         end else begin : g_next
            assign valid_p = valid_ff[k-1];
            assign rem_p   = rem_ff[k-1];
            assign num_p   = num_ff[k-1];
            assign quo_p   = quo_ff[k-1];
            assign den_p   = den_ff[k-1];
            assign side_p  = side_ff[k-1];
         end

         // Bring down one numerator bit and try to subtract the divisor.
         always_comb begin
            trial = {rem_p, num_p[NUM_W-1]};
            qbit  = (trial >= {1'b0, den_p});
            if (qbit) begin
               rem_in = DEN_W'(trial - {1'b0, den_p});
            end else begin
               rem_in = trial[DEN_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (enable) begin
               valid_ff[k] <= valid_p;
            end
            if (enable) begin
               rem_ff[k]  <= rem_in;
               num_ff[k]  <= num_p << 1;
               quo_ff[k]  <= {quo_p[NUM_W-2:0], qbit};
               den_ff[k]  <= den_p;
               side_ff[k] <= side_p;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = quo_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

/* rtl/wcs_back.sv */
// Back end: texture column, wall height, clipped span and texture stepping.
// Depends on wcs_pkg and wcs_divider.
module wcs_back #(
   parameter int FRAC_BITS = wcs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  wcs_pkg::view_config_type    cfg,
   input  logic                        queue_empty,
   input  wcs_pkg::column_item_type    queue_item,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output wcs_pkg::rsp_payload_type    rsp_payload
);
   import wcs_pkg::*;

   localparam int F2     = 2 * FRAC_BITS;
   localparam int HW     = 12 + FRAC_BITS;
   localparam int SW     = 11 + FRAC_BITS;
   localparam int SIDE1  = 12 + 10;
   localparam int SIDE2  = 12 + 10 + 11 + 11 + 26;

   logic enable;

   // Stage one: hit position fraction.
   logic               s1_valid_ff;
   logic [11:0]        s1_col_ff;
   logic [31:0]        s1_dist_ff;
   logic [F2-1:0]      s1_frac_ff, s1_frac_in;
   logic               s1_mirror_ff;
   logic signed [52:0] hit_prod;
   logic [63:0]        hit_wide;

   // Stage two: texture column.
   logic               s2_valid_ff;
   logic [11:0]        s2_col_ff;
   logic [31:0]        s2_dist_ff;
   logic [9:0]         s2_texcol_ff, s2_texcol_in;
   logic [F2+10:0]     tex_prod;
   logic [10:0]        tex_raw;

   // First divider and stage three: span.
   logic               d1_valid;
   logic [HW-1:0]      d1_quo;
   logic [SIDE1-1:0]   d1_side;
   logic               s3_valid_ff;
   logic [HW-1:0]      s3_height_ff, s3_height_in;
   logic [SIDE2-1:0]   s3_side_ff, s3_side_in;
   logic [HW-2:0]      half_h;
   logic [10:0]        half_view;
   logic [10:0]        first_in, last_in;
   logic [HW-1:0]      last_sum;
   logic [63:0]        offset_wide;

   // Second divider and the output register.
   logic               d2_valid;
   logic [SW-1:0]      d2_quo;
   logic [SIDE2-1:0]   d2_side;
   logic [63:0]        step_wide;
   logic [26:0]        step_in;
   logic [51:0]        start_prod;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   assign enable      = !(rsp_valid_ff && rsp_stall);
   assign pop         = enable && !queue_empty;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Hit position with twice the fraction bits, kept modulo one map unit.
   always_comb begin
      hit_prod   = $signed({1'b0, queue_item.distance}) * queue_item.direction;
      hit_wide   = (64'(queue_item.coord) << FRAC_BITS) + 64'(hit_prod);
      s1_frac_in = hit_wide[F2-1:0];
   end

   // Scale the fraction by the texture width and mirror where needed.
   always_comb begin
      tex_prod = (F2+11)'(s1_frac_ff) * (F2+11)'(cfg.texture_columns);
      tex_raw  = tex_prod[F2+10:F2];
      if (s1_mirror_ff) begin
         s2_texcol_in = 10'(cfg.texture_columns - tex_raw - 11'd1);
      end else begin
         s2_texcol_in = tex_raw[9:0];
      end
   end

   wcs_divider #(.NUM_W(HW), .DEN_W(32), .SIDE_W(SIDE1)) u_height_div (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (s2_valid_ff),
      .in_num   ({cfg.view_rows, FRAC_BITS'(0)}),
      .in_den   (s2_dist_ff),
      .in_side  ({s2_col_ff, s2_texcol_ff}),
      .out_valid(d1_valid),
      .out_quo  (d1_quo),
      .out_side (d1_side)
   );

   // Wall height with a floor of one, then the span clipped to the view.
   always_comb begin
      s3_height_in = (d1_quo == '0) ? HW'(1) : d1_quo;
      half_h       = s3_height_in[HW-1:1];
      half_view    = cfg.view_rows[11:1];
      if (HW'(half_h) >= HW'(half_view)) begin
         first_in = '0;
      end else begin
         first_in = 11'(half_view - 11'(half_h));
      end
      last_sum = HW'(half_h) + HW'(half_view);
      if (last_sum >= HW'(cfg.view_rows)) begin
         last_in = 11'(cfg.view_rows - 12'd1);
      end else begin
         last_in = last_sum[10:0];
      end
      if (HW'(half_h) > HW'(half_view)) begin
         offset_wide = 64'(HW'(half_h) - HW'(half_view));
      end else begin
         offset_wide = '0;
      end
      s3_side_in = {d1_side, first_in, last_in, offset_wide[25:0]};
   end

   wcs_divider #(.NUM_W(SW), .DEN_W(HW), .SIDE_W(SIDE2)) u_step_div (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (s3_valid_ff),
      .in_num   ({cfg.texture_rows, FRAC_BITS'(0)}),
      .in_den   (s3_height_ff),
      .in_side  (s3_side_ff),
      .out_valid(d2_valid),
      .out_quo  (d2_quo),
      .out_side (d2_side)
   );

   // Texture step and the start position at the first drawn row.
   always_comb begin
      step_wide  = 64'(d2_quo);
      step_in    = step_wide[26:0];
      start_prod = 52'(d2_side[25:0]) * 52'(step_in[25:0]);
      rsp_payload_in.column_out   = d2_side[SIDE2-1 -: 12];
      rsp_payload_in.texel_column = d2_side[SIDE2-13 -: 10];
      rsp_payload_in.first_row    = d2_side[47:37];
      rsp_payload_in.last_row     = d2_side[36:26];
      rsp_payload_in.texel_start  = start_prod[25:0];
      rsp_payload_in.texel_step   = step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff  <= !queue_empty;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= d1_valid;
         rsp_valid_ff <= d2_valid;
      end
      if (enable) begin
         s1_col_ff      <= queue_item.column;
         s1_dist_ff     <= queue_item.distance;
         s1_frac_ff     <= s1_frac_in;
         s1_mirror_ff   <= queue_item.mirror;
         s2_col_ff      <= s1_col_ff;
         s2_dist_ff     <= s1_dist_ff;
         s2_texcol_ff   <= s2_texcol_in;
         s3_height_ff   <= s3_height_in;
         s3_side_ff     <= s3_side_in;
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

/* rtl/wall_column_span_setup_top.sv */
// Top level of the wall column span setup block: register file and wiring.
// Depends on wcs_pkg, wcs_front, wcs_queue and wcs_back.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_payload_type
//   rsp_      out        rsp_valid/rsp_stall  rsp_payload_type
//   csr_      in/out     psel/penable/pready  32-bit registers at 0, 4, 8
//
// One column is accepted per cycle while req_stall is low; the span is set up by
// the two bit-per-stage divider pipelines (height, then texture step).
// Reset is synchronous, clears all valid flags and sets the registers to their reset values.
// An output stall freezes the back end; the queue then fills and the front stalls.
module wall_column_span_setup_top #(
   parameter int FRAC_BITS = wcs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  wcs_pkg::req_payload_type           req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output wcs_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [wcs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [wcs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [wcs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import wcs_pkg::*;

   logic [11:0]     view_rows_ff;
   logic [10:0]     tex_cols_ff;
   logic [10:0]     tex_rows_ff;
   reg_index_type   reg_index;
   logic            csr_write;
   view_config_type cfg;

   logic            push_valid, queue_full, queue_empty, pop;
   column_item_type push_item, queue_item;

   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   // Register writes; an unknown address is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         view_rows_ff <= VIEW_RESET;
         tex_cols_ff  <= TEX_COLS_RESET;
         tex_rows_ff  <= TEX_ROWS_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_VIEW_ROWS:       view_rows_ff <= csr_pwdata[11:0];
            REG_TEXTURE_COLUMNS: tex_cols_ff  <= csr_pwdata[10:0];
            REG_TEXTURE_ROWS:    tex_rows_ff  <= csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (reg_index)
         REG_VIEW_ROWS:       csr_prdata = CSR_DATA_W'(view_rows_ff);
         REG_TEXTURE_COLUMNS: csr_prdata = CSR_DATA_W'(tex_cols_ff);
         REG_TEXTURE_ROWS:    csr_prdata = CSR_DATA_W'(tex_rows_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // A zero setting counts as one, values above the bound saturate.
   always_comb begin
      if (view_rows_ff == '0) begin
         cfg.view_rows = 12'd1;
      end else if (view_rows_ff > VIEW_MAX) begin
         cfg.view_rows = VIEW_MAX;
      end else begin
         cfg.view_rows = view_rows_ff;
      end
      if (tex_cols_ff == '0) begin
         cfg.texture_columns = 11'd1;
      end else if (tex_cols_ff > TEX_MAX) begin
         cfg.texture_columns = TEX_MAX;
      end else begin
         cfg.texture_columns = tex_cols_ff;
      end
      if (tex_rows_ff == '0) begin
         cfg.texture_rows = 11'd1;
      end else if (tex_rows_ff > TEX_MAX) begin
         cfg.texture_rows = TEX_MAX;
      end else begin
         cfg.texture_rows = tex_rows_ff;
      end
   end

   wcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_full  (queue_full)
   );

   wcs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_item (push_item),
      .full      (queue_full),
      .pop_req   (pop),
      .empty     (queue_empty),
      .pop_item  (queue_item)
   );

   wcs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .queue_empty(queue_empty),
      .queue_item (queue_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule
